FILE: rtl/vote_debounce_transition_counter_core_assert.svh
// Assertion macros used by the vote debounce transition counter RTL.
`ifndef VOTE_DEBOUNCE_TRANSITION_COUNTER_CORE_ASSERT_SVH
`define VOTE_DEBOUNCE_TRANSITION_COUNTER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VDTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vdtc assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define VDTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vdtc assertion failed");

`endif

FILE: rtl/vdtc_pkg.sv
// Package with the types and constants of the vote debounce transition counter.
package vdtc_pkg;

	localparam int unsigned PIN_W = 4;
	localparam int unsigned TRANS_W = 5;
	localparam int unsigned CFG_W = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_CHANNELS = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd1;

	localparam logic [CFG_W-1:0] SAMPLES_PER_WINDOW_RST = 4'd10;
	localparam logic [CFG_W-1:0] VOTE_THRESHOLD_RST = 4'd7;
	localparam logic [CFG_W-1:0] COUNT_MAX = 4'd15;

	typedef struct packed {
		logic sample_en;
		logic window_end;
		logic [CFG_W-1:0] threshold;
	} lane_ctrl_t;

	typedef struct packed {
		logic [PIN_W-1:0] qualified_touch;
		logic [PIN_W-1:0] direct_state;
		logic [TRANS_W-1:0] transitions_ch0;
		logic [TRANS_W-1:0] transitions_ch1;
		logic [TRANS_W-1:0] transitions_ch2;
		logic [TRANS_W-1:0] transitions_ch3;
	} result_t;

endpackage

FILE: rtl/vdtc_sample_if.sv
// Handshake interface that carries one raw pin sample per transaction.
interface vdtc_sample_if
	import vdtc_pkg::*;
	();
	logic valid;
	logic ready;
	logic [PIN_W-1:0] contact_pins;
	logic [PIN_W-1:0] direct_pins;

	modport source (output valid, output contact_pins, output direct_pins, input ready);
	modport sink (input valid, input contact_pins, input direct_pins, output ready);
endinterface

FILE: rtl/vdtc_result_if.sv
// Handshake interface that carries one window decision per transaction.
interface vdtc_result_if
	import vdtc_pkg::*;
	();
	logic valid;
	logic ready;
	logic [PIN_W-1:0] qualified_touch;
	logic [PIN_W-1:0] direct_state;
	logic [TRANS_W-1:0] transitions_ch0;
	logic [TRANS_W-1:0] transitions_ch1;
	logic [TRANS_W-1:0] transitions_ch2;
	logic [TRANS_W-1:0] transitions_ch3;

	modport source (output valid, output qualified_touch, output direct_state,
		output transitions_ch0, output transitions_ch1, output transitions_ch2,
		output transitions_ch3, input ready);
	modport sink (input valid, input qualified_touch, input direct_state,
		input transitions_ch0, input transitions_ch1, input transitions_ch2,
		input transitions_ch3, output ready);
endinterface

FILE: rtl/vdtc_lane.sv
// One channel lane: low-sample vote, rotating decision history and transition count.
module vdtc_lane
	import vdtc_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 20,
	parameter int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  lane_ctrl_t ctrl,
	input  logic contact,
	output logic touched,
	output logic [CNT_W-1:0] trans_next
);

	logic [CFG_W-1:0] low_q;
	logic [CFG_W-1:0] low_next;
	logic [HISTORY_DEPTH-1:0] hist_q;
	logic [CNT_W-1:0] trans_q;
	logic [1:0] removed;
	logic [1:0] added;
	logic slot_bit;
	logic prev_bit;
	logic next_bit;

	// The history rotates so that the slot being written always sits at bit 0.
	assign slot_bit = hist_q[0];
	assign next_bit = hist_q[1];
	assign prev_bit = hist_q[HISTORY_DEPTH-1];

	always_comb begin
		low_next = low_q;
		if (!contact && (low_q != COUNT_MAX)) begin
			low_next = low_q + 1'b1;
		end
	end

	assign touched = (low_next >= ctrl.threshold);

	always_comb begin
		removed = 2'(slot_bit ^ prev_bit) + 2'(slot_bit ^ next_bit);
		added = 2'(touched ^ prev_bit) + 2'(touched ^ next_bit);
		trans_next = trans_q + CNT_W'(added) - CNT_W'(removed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			hist_q <= '0;
			trans_q <= '0;
		end else if (ctrl.sample_en) begin
			if (ctrl.window_end) begin
				low_q <= '0;
				hist_q <= {touched, hist_q[HISTORY_DEPTH-1:1]};
				trans_q <= trans_next;
			end else begin
				low_q <= low_next;
			end
		end
	end

endmodule

FILE: rtl/vdtc_merge.sv
// Merge stage: gathers the lane decisions into a result and buffers it in two slots.
module vdtc_merge
	import vdtc_pkg::*;
#(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned CNT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [CHANNELS-1:0] touched,
	input  logic [CHANNELS-1:0][CNT_W-1:0] trans,
	input  logic [PIN_W-1:0] direct_pins,
	output logic space,
	vdtc_result_if.source results
);

	logic [OUT_CHANNELS-1:0] qual;
	logic [OUT_CHANNELS-1:0][TRANS_W-1:0] counts;
	result_t merged;
	result_t main_q;
	result_t skid_q;
	logic main_valid_q;
	logic skid_valid_q;
	logic pop;

	for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_out
		if (c < CHANNELS) begin : g_used
			logic [CNT_W+TRANS_W-1:0] wide;
			assign wide = {{TRANS_W{1'b0}}, trans[c]};
			assign qual[c] = touched[c];
			assign counts[c] = wide[TRANS_W-1:0];
		end else begin : g_unused
			assign qual[c] = 1'b0;
			assign counts[c] = '0;
		end
	end

	always_comb begin
		merged.qualified_touch = qual;
		merged.direct_state = ~direct_pins;
		merged.transitions_ch0 = counts[0];
		merged.transitions_ch1 = counts[1];
		merged.transitions_ch2 = counts[2];
		merged.transitions_ch3 = counts[3];
	end

	assign pop = main_valid_q && results.ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= merged;
				end
			end else if (push) begin
				main_q <= merged;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= merged;
			end else begin
				main_q <= merged;
			end
		end
	end

	assign results.valid = main_valid_q;
	assign results.qualified_touch = main_q.qualified_touch;
	assign results.direct_state = main_q.direct_state;
	assign results.transitions_ch0 = main_q.transitions_ch0;
	assign results.transitions_ch1 = main_q.transitions_ch1;
	assign results.transitions_ch2 = main_q.transitions_ch2;
	assign results.transitions_ch3 = main_q.transitions_ch3;

endmodule

FILE: rtl/vote_debounce_transition_counter_core.sv
// Throughput: one sample transaction per cycle while the skid slot is free; each lane
// updates its vote on each accepted sample, and its history and transition count on the
// sample ending a window, whose result is registered in the merge main or skid slot.
// A two-slot result buffer lets samples keep flowing while one result waits.
// Reset clears the counters and histories at once and loads the register defaults.
module vote_debounce_transition_counter_core
	import vdtc_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 20,
	parameter int unsigned CHANNELS = 4
) (
	input  logic clk,
	input  logic arst_n,
	vdtc_sample_if.sink samples,
	vdtc_result_if.source results,
	input  logic wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	`include "vote_debounce_transition_counter_core_assert.svh"

	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

	logic [CFG_W-1:0] spw_q;
	logic [CFG_W-1:0] thr_q;
	logic [CFG_W-1:0] sample_cnt_q;
	logic [CFG_W-1:0] cnt_inc;
	logic [CFG_W-1:0] window;
	logic window_end;
	logic fire;
	logic space;
	lane_ctrl_t ctrl;
	logic [CHANNELS-1:0] touched;
	logic [CHANNELS-1:0][CNT_W-1:0] trans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spw_q <= SAMPLES_PER_WINDOW_RST;
			thr_q <= VOTE_THRESHOLD_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SAMPLES_PER_WINDOW: spw_q <= wr_data;
				REG_VOTE_THRESHOLD: thr_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign samples.ready = space;
	assign fire = samples.valid && space;
	assign cnt_inc = (sample_cnt_q == COUNT_MAX) ? COUNT_MAX : sample_cnt_q + 1'b1;
	assign window = (spw_q == '0) ? CFG_W'(1) : spw_q;
	assign window_end = (cnt_inc >= window);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_cnt_q <= '0;
		end else if (fire) begin
			sample_cnt_q <= window_end ? '0 : cnt_inc;
		end
	end

	always_comb begin
		ctrl.sample_en = fire;
		ctrl.window_end = window_end;
		ctrl.threshold = thr_q;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic contact;
		if (c < PIN_W) begin : g_pin
			assign contact = samples.contact_pins[c];
		end else begin : g_nopin
			assign contact = 1'b0;
		end

		vdtc_lane #(
			.HISTORY_DEPTH(HISTORY_DEPTH),
			.CNT_W(CNT_W)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.contact(contact),
			.touched(touched[c]),
			.trans_next(trans[c])
		);
	end

	vdtc_merge #(
		.CHANNELS(CHANNELS),
		.CNT_W(CNT_W)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire && window_end),
		.touched(touched),
		.trans(trans),
		.direct_pins(samples.direct_pins),
		.space(space),
		.results(results)
	);

	`VDTC_ASSERT_NEXT(a_window_restart, clk, arst_n, fire && window_end, sample_cnt_q == '0)
	`VDTC_ASSERT_NEXT(a_no_spurious_result, clk, arst_n,
		!results.valid && !(fire && window_end), !results.valid)
	`VDTC_ASSERT_SAME(a_ring_count_even, clk, arst_n, results.valid,
		results.transitions_ch0[0] == 1'b0)
	`VDTC_ASSERT_NEXT(a_threshold_write, clk, arst_n,
		wr_en && (wr_index == REG_VOTE_THRESHOLD), thr_q == $past(wr_data))

endmodule
